// ----- src/psgfs_pkg.sv -----
package psgfs_pkg;

    // Default geometry of the table
    localparam int DEPTH_DEF    = 1024;
    localparam int VALUE_W_DEF  = 32;

    // Payload field widths
    localparam int MODE_W       = 1;
    localparam int INDEX_W      = 10;
    localparam int NEW_VALUE_W  = 32;
    localparam int TOTAL_W      = 42;

    // Configuration register
    localparam int CFG_W        = 11;
    localparam int ACTIVE_RESET = 1024;

    // APB port
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_IDX_LSB  = 2;
    localparam int REG_IDX_W    = APB_ADDR_W - REG_IDX_LSB;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE = '0;

    // Width of the fill epoch tag kept with every entry
    localparam int EPOCH_W      = 8;

    localparam logic [MODE_W-1:0] MODE_POINT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FILL  = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// ----- src/psgfs_req_if.sv -----
interface psgfs_req_if;
    import psgfs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [INDEX_W-1:0]     index;
    logic [NEW_VALUE_W-1:0] new_value;

    modport source (output valid, output mode, output index, output new_value, input ready);
    modport sink   (input valid, input mode, input index, input new_value, output ready);
endinterface

// ----- src/psgfs_rsp_if.sv -----
interface psgfs_rsp_if;
    import psgfs_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total;
    logic               bad_index;

    modport source (output valid, output total, output bad_index, input ready);
    modport sink   (input valid, input total, input bad_index, output ready);
endinterface

// ----- src/point_set_global_fill_sum_top.sv -----
// Table of DEPTH entries with a running sum of the first active_entries.
// Request channel i_req (valid/ready): mode selects a point write of
// new_value at index, or a fill of every active entry with new_value.
// Response channel o_rsp (valid/ready): one item per request with the new
// total (clamped to 42 bits) and bad_index, set when a point write names an
// entry that is not in use; such a write changes nothing.
// The request and the entry read are registered on acceptance; the update
// state then registers the response. A new request is accepted only after
// the previous one has left the update state and written back its entry.
// The response register lets the next request be accepted while a response
// waits; if the receiver stalls longer, the second request holds in its
// update cycle until the response register frees.
// Each entry stores its value with the fill epoch it was written in; a fill
// bumps the epoch, so older entries read as the fill value.
// After reset, after each write of active_entries (APB, byte address 0) and
// after every 255th fill, a clearing pass over all DEPTH entries resets
// the epoch tags; no request is accepted during it. A register write also
// zeroes the fill value and the total.
module point_set_global_fill_sum_top #(
    parameter int DEPTH       = psgfs_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = psgfs_pkg::VALUE_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psgfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [psgfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [psgfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    psgfs_req_if.sink                       i_req,
    psgfs_rsp_if.source                     o_rsp
);
    import psgfs_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = VALUE_WIDTH + CNT_W;
    localparam int MAX_A   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int MAX_B   = (MAX_A > CFG_W) ? MAX_A : CFG_W;
    localparam int CMP_W   = MAX_B + 1;
    localparam int CLAMP_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
    localparam int MEM_W   = EPOCH_W + VALUE_WIDTH;
    localparam int EFF_RST = (ACTIVE_RESET > DEPTH) ? DEPTH : ACTIVE_RESET;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [AW-1:0]      ADDR_LAST   = AW'(DEPTH - 1);

    logic                   r_state, n_state;
    logic                   r_clearing, n_clearing;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0]     r_epoch, n_epoch;
    logic [VALUE_WIDTH-1:0] r_fill, n_fill;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CFG_W-1:0]       r_active, n_active;
    logic [CNT_W-1:0]       r_eff, n_eff;
    logic                   r_out_valid, n_out_valid;

    logic [MODE_W-1:0]      r_req_mode;
    logic                   r_req_bad;
    logic [AW-1:0]          r_req_addr;
    logic [VALUE_WIDTH-1:0] r_req_val;
    logic [TOTAL_W-1:0]     r_total;
    logic                   r_bad;

    logic [MEM_W-1:0]       mem [DEPTH];
    logic [MEM_W-1:0]       r_rd_data;

    logic                   cfg_hit;
    logic [CFG_W-1:0]       cfg_val;
    logic                   in_acc;
    logic                   out_take;
    logic                   exec_done;
    logic [CMP_W-1:0]       idx_w;
    logic                   in_bad;
    logic [AW-1:0]          in_addr;
    logic [EPOCH_W-1:0]     rd_tag;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic [VALUE_WIDTH-1:0] old_val;
    logic [SUM_W-1:0]       fill_sum;
    logic [SUM_W-1:0]       point_sum;
    logic [SUM_W-1:0]       exec_sum;
    logic [CLAMP_W-1:0]     sum_ext;
    logic [TOTAL_W-1:0]     exec_total;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [MEM_W-1:0]       wr_data;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_val = pwdata[CFG_W-1:0];
    assign cfg_hit = psel && penable && pwrite
                     && (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_ACTIVE);
    assign prdata  = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_ACTIVE)
                     ? APB_DATA_W'(r_active) : '0;

    // Handshakes
    assign i_req.ready     = (r_state == ST_IDLE) && !r_clearing;
    assign in_acc          = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.total     = r_total;
    assign o_rsp.bad_index = r_bad;
    assign out_take        = r_out_valid && o_rsp.ready;
    assign exec_done       = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    assign idx_w   = CMP_W'(i_req.index);
    assign in_bad  = idx_w >= CMP_W'(r_eff);
    assign in_addr = idx_w[AW-1:0];

    // An entry tagged with an older epoch reads as the fill value
    assign rd_tag  = r_rd_data[MEM_W-1:VALUE_WIDTH];
    assign rd_val  = r_rd_data[VALUE_WIDTH-1:0];
    assign old_val = (rd_tag == r_epoch) ? rd_val : r_fill;

    assign fill_sum  = SUM_W'(r_req_val) * SUM_W'(r_eff);
    assign point_sum = r_sum - SUM_W'(old_val) + SUM_W'(r_req_val);

    always_comb begin
        if (r_req_mode == MODE_FILL) begin
            exec_sum = fill_sum;
        end else if (r_req_bad) begin
            exec_sum = r_sum;
        end else begin
            exec_sum = point_sum;
        end
    end

    assign sum_ext    = CLAMP_W'(exec_sum);
    assign exec_total = (sum_ext > CLAMP_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

    // Single write port, shared by the clearing pass and the update
    assign wr_en   = r_clearing
                     || (exec_done && (r_req_mode == MODE_POINT) && !r_req_bad);
    assign wr_addr = r_clearing ? r_clr_addr : r_req_addr;
    assign wr_data = r_clearing ? '0 : {r_epoch, r_req_val};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[in_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clearing  = r_clearing;
        n_clr_addr  = r_clr_addr;
        n_epoch     = r_epoch;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_active    = r_active;
        n_eff       = r_eff;
        n_out_valid = r_out_valid;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        // Advance the clearing pass
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == ADDR_LAST) begin
                n_clearing = 1'b0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_sum       = exec_sum;
                    if (r_req_mode == MODE_FILL) begin
                        n_fill = r_req_val;
                        // Out of epochs: retag every entry before the next item
                        if (r_epoch == EPOCH_LAST) begin
                            n_epoch    = EPOCH_FIRST;
                            n_clearing = 1'b1;
                            n_clr_addr = '0;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_hit) begin
            n_active   = cfg_val;
            n_eff      = (CMP_W'(cfg_val) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cfg_val);
            n_fill     = '0;
            n_sum      = '0;
            n_epoch    = EPOCH_FIRST;
            n_clearing = 1'b1;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_fill      <= '0;
            r_sum       <= '0;
            r_active    <= CFG_W'(ACTIVE_RESET);
            r_eff       <= CNT_W'(EFF_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clearing  <= n_clearing;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_active    <= n_active;
            r_eff       <= n_eff;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the request and the response payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req_mode <= i_req.mode;
            r_req_addr <= in_addr;
            r_req_val  <= VALUE_WIDTH'(i_req.new_value);
            r_req_bad  <= in_bad && (i_req.mode == MODE_POINT);
        end
        if (exec_done) begin
            r_total <= exec_total;
            r_bad   <= r_req_bad;
        end
    end

`ifndef SYNTHESIS
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_clearing && (r_sum == '0)))
        else $error("register write did not clear the table");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_EXEC))
        else $error("accepted item did not enter update");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch aliases the cleared tag");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !exec_done)
        else $error("update during clearing pass");
`endif

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psgfs_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [INDEX_W-1:0]     index;
        logic [NEW_VALUE_W-1:0] new_value;
    } t_table_req;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               bad_index;
    } t_table_rsp;

    // Outlast the clearing pass after a register write so the block fills up
    localparam int LONG_HOLD = 1600;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    psgfs_req_if req_if();
    psgfs_rsp_if rsp_if();

    point_set_global_fill_sum_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Table model: stored values, written-since-fill flags, fill value, exact sum
    bit [NEW_VALUE_W-1:0] entry_val [DEPTH_DEF];
    bit                   entry_fresh [DEPTH_DEF];
    bit [NEW_VALUE_W-1:0] fill_val;
    longint unsigned      table_sum;
    int                   active_cnt;

    t_table_req pending_requests[$];
    t_table_rsp expected_sums[$];
    t_table_req next_req;

    int  n_queued, n_checked, n_errors;
    int  n_points, n_fills, n_bad, n_settings;
    int  tx_wait, rx_wait, hold_left;
    int  hold_ticket, hold_served;
    bit  tx_burst, rx_burst;
    bit  req_taken, rsp_taken;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void clear_model(int count);
        foreach (entry_fresh[i]) begin
            entry_fresh[i] = 1'b0;
            entry_val[i]   = '0;
        end
        fill_val   = '0;
        table_sum  = 0;
        active_cnt = count;
    endfunction

    function automatic t_table_rsp update_sum_model(t_table_req r);
        t_table_rsp      p;
        longint unsigned v;
        longint unsigned prior;
        int              eff;
        eff         = (active_cnt > DEPTH_DEF) ? DEPTH_DEF : active_cnt;
        v           = r.new_value;
        p.bad_index = 1'b0;
        if (r.mode == MODE_FILL) begin
            foreach (entry_fresh[i]) entry_fresh[i] = 1'b0;
            fill_val  = r.new_value;
            table_sum = v * longint'(eff);
        end else if (int'(r.index) >= eff) begin
            p.bad_index = 1'b1;
        end else begin
            prior = entry_fresh[r.index] ? entry_val[r.index] : fill_val;
            table_sum = table_sum - prior + v;
            entry_val[r.index]   = r.new_value;
            entry_fresh[r.index] = 1'b1;
        end
        p.total = (table_sum > TOTAL_MAX) ? TOTAL_MAX : table_sum[TOTAL_W-1:0];
        return p;
    endfunction

    function automatic logic [NEW_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range point writes and fills, some rejected indices, some raw noise
    function automatic t_table_req random_request(int fill_share);
        t_table_req r;
        int         pick;
        pick        = $urandom_range(0, 19);
        r.mode      = MODE_POINT;
        r.index     = INDEX_W'($urandom);
        r.new_value = pick_value();
        if (pick < fill_share)
            r.mode = MODE_FILL;
        else if (pick < 17)
            r.index = INDEX_W'($urandom_range(0, active_cnt - 1));
        else if (pick < 19 && active_cnt < DEPTH_DEF)
            r.index = INDEX_W'($urandom_range(active_cnt, DEPTH_DEF - 1));
        return r;
    endfunction

    task automatic push_req(logic [MODE_W-1:0] mode, int idx, logic [NEW_VALUE_W-1:0] val);
        t_table_req r;
        r.mode      = mode;
        r.index     = INDEX_W'(idx);
        r.new_value = val;
        pending_requests = {pending_requests, r};
        n_queued++;
    endtask

    task automatic push_random(int n, int fill_share);
        repeat (n) begin
            pending_requests = {pending_requests, random_request(fill_share)};
            n_queued++;
        end
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_active(int count);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_ACTIVE, {REG_IDX_LSB{1'b0}}};
        pwdata  = count;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        clear_model(count);
        n_settings++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(int count, int n, int fill_share, bit tx_b, bit rx_b, bit hold);
        wait_idle();
        write_active(count);
        tx_burst = tx_b;
        rx_burst = rx_b;
        push_random(n, fill_share);
        if (hold) hold_ticket++;
    endtask

    // Request driver: new item or gap at each falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (tx_wait != 0) begin
                tx_wait--;
                req_if.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                next_req = pending_requests.pop_front();
                req_if.mode      <= next_req.mode;
                req_if.index     <= next_req.index;
                req_if.new_value <= next_req.new_value;
                req_if.valid     <= 1'b1;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 18);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response ready: per-item stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_taken)
                rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
            else if (rx_wait != 0)
                rx_wait--;
            rsp_if.ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_table_req got_req;
        t_table_rsp want;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        rsp_taken <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            got_req.mode      = req_if.mode;
            got_req.index     = req_if.index;
            got_req.new_value = req_if.new_value;
            want = update_sum_model(got_req);
            expected_sums = {expected_sums, want};
            if (got_req.mode == MODE_FILL) n_fills++;
            else n_points++;
            if (want.bad_index) n_bad++;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: result with nothing pending: total=%0d bad_index=%0b",
                         $realtime, rsp_if.total, rsp_if.bad_index);
                n_errors++;
            end else begin
                want = expected_sums.pop_front();
                n_checked++;
                if (rsp_if.total !== want.total) begin
                    $display("%0t: total mismatch: expected %0d, got %0d",
                             $realtime, want.total, rsp_if.total);
                    n_errors++;
                end
                if (rsp_if.bad_index !== want.bad_index) begin
                    $display("%0t: bad_index mismatch: expected %0b, got %0b",
                             $realtime, want.bad_index, rsp_if.bad_index);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_POINT;
        req_if.index     = '0;
        req_if.new_value = '0;
        rsp_if.ready     = 1'b0;
        clear_model(ACTIVE_RESET);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full table after reset: extremes, overwrite, fill with ignored index
        push_req(MODE_POINT, 0, 32'hFFFF_FFFF);
        push_req(MODE_POINT, DEPTH_DEF - 1, 32'hFFFF_FFFF);
        push_req(MODE_POINT, 0, 32'h0);
        push_req(MODE_FILL, DEPTH_DEF - 1, 32'hFFFF_FFFF);
        push_req(MODE_POINT, 512, 32'h0);
        push_req(MODE_POINT, 512, 32'h1234_5678);
        push_req(MODE_FILL, 0, 32'h0);
        push_req(MODE_POINT, DEPTH_DEF - 1, 32'h1);
        push_req(MODE_FILL, 77, 32'h8000_0000);
        push_req(MODE_POINT, 0, 32'h7FFF_FFFF);
        push_req(MODE_FILL, 3, 32'hFFFF_FFFF);
        push_req(MODE_FILL, 4, 32'hFFFF_FFFF);
        push_req(MODE_POINT, 1, 32'hAAAA_AAAA);
        push_req(MODE_POINT, 2, 32'h5555_5555);
        push_random(100, 5);

        // Single active entry: everything past index 0 is rejected
        wait_idle();
        write_active(1);
        push_req(MODE_POINT, 0, 32'h5);
        push_req(MODE_POINT, 1, 32'h7);
        push_req(MODE_POINT, DEPTH_DEF - 1, 32'hFFFF_FFFF);
        push_req(MODE_FILL, DEPTH_DEF - 1, 32'hFFFF_FFFF);
        push_req(MODE_POINT, 0, 32'h0);
        push_req(MODE_FILL, 0, 32'h0);
        push_random(120, 5);

        // Back-to-back sender against a stalled receiver
        run_phase(DEPTH_DEF, 160, 5, 1'b1, 1'b0, 1'b1);
        run_phase(2, 150, 14, 1'b0, 1'b1, 1'b0);
        run_phase($urandom_range(3, DEPTH_DEF - 1), 150, 5, 1'b0, 1'b0, 1'b0);
        run_phase($urandom_range(3, DEPTH_DEF - 1), 150, 8, 1'b1, 1'b1, 1'b0);
        run_phase($urandom_range(3, 64), 150, 5, 1'b0, 1'b0, 1'b0);
        run_phase($urandom_range(3, DEPTH_DEF - 1), 150, 3, 1'b1, 1'b0, 1'b0);
        run_phase(DEPTH_DEF - 1, 100, 5, 1'b0, 1'b0, 1'b0);

        wait_idle();
        $display("Checked %0d results: %0d point writes (%0d rejected), %0d fills,",
                 n_checked, n_points, n_bad, n_fills);
        $display("over %0d register settings, with random and long receiver stalls.",
                 n_settings + 1);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", n_queued - n_checked);
        $display("tb_top failed");
        $finish;
    end

endmodule
